FILE: src/hswm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hswm_pkg: shared types and constants for the horizontal span word masks
// Geometry constants, configuration register indexes and the span record
// that the front end hands to the word generator.
// ----------------------------------------------------------------------------
package hswm_pkg;

  localparam int WORD_BITS  = 32;
  localparam int WB_LOG     = $clog2(WORD_BITS);
  localparam int ROW_PAD    = 8;
  localparam int DIM_W      = 10;                    // display width/height
  localparam int STRIDE_W   = DIM_W + 1;             // width + pad
  localparam int BIT_W      = DIM_W + STRIDE_W;      // linear bit offset
  localparam int IDX_W      = 16;                    // word index field
  localparam int COORD_W    = 12;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(360);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(288);

  // first and last bit of a clipped line, plus its colour
  typedef struct packed {
    logic [BIT_W-1:0] start_bit;
    logic [BIT_W-1:0] end_bit;
    logic [COL_W-1:0] colour;
  } span_t;

endpackage

FILE: src/hswm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hswm_front: line request intake and clipping
// Clips a request to the display, drops lines with nothing visible and
// registers the linear bit range of what remains.
// ----------------------------------------------------------------------------
module hswm_front import hswm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [DIM_W-1:0]          display_width_i,
  input  logic [DIM_W-1:0]          display_height_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0]        line_length_i,
  input  logic [COL_W-1:0]          colour_i,
  output logic                      span_valid_o,
  input  logic                      span_full_i,
  output span_t                     span_o
);

  logic                      valid_q, valid_d;
  span_t                     span_q, span_d;
  logic                      accept;
  logic                      off_screen, y_ge, x_ge;
  logic signed [COORD_W+1:0] endx_raw;
  logic                      end_gt_w, end_nonpos;
  logic [DIM_W:0]            endx_c;
  logic [DIM_W-1:0]          from_x;
  logic [STRIDE_W-1:0]       stride;
  logic [BIT_W-1:0]          row_base;
  logic                      keep;

  assign in_stall_o = valid_q && span_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    y_ge       = !start_y_i[COORD_W-1] &&
                 (start_y_i[COORD_W-2:0] >= (COORD_W-1)'(display_height_i));
    x_ge       = !start_x_i[COORD_W-1] &&
                 (start_x_i[COORD_W-2:0] >= (COORD_W-1)'(display_width_i));
    off_screen = start_y_i[COORD_W-1] || y_ge || x_ge;
    endx_raw   = (COORD_W+2)'(start_x_i) + $signed({2'b00, line_length_i});
    end_gt_w   = endx_raw > $signed((COORD_W+2)'({1'b0, display_width_i}));
    end_nonpos = endx_raw[COORD_W+1] || (endx_raw == '0);
    endx_c     = end_gt_w ? {1'b0, display_width_i} : endx_raw[DIM_W:0];
    from_x     = start_x_i[COORD_W-1] ? '0 : start_x_i[DIM_W-1:0];
    keep       = !off_screen && !end_nonpos && (endx_c > {1'b0, from_x});
    stride     = {1'b0, display_width_i} + STRIDE_W'(ROW_PAD);
    row_base   = BIT_W'(start_y_i[DIM_W-1:0]) * BIT_W'(stride);
    // end bit = base + from_x + 1 + (clipped length - 1) = base + clipped end x
    span_d.start_bit = row_base + BIT_W'(from_x) + BIT_W'(1);
    span_d.end_bit   = row_base + BIT_W'(endx_c);
    span_d.colour    = colour_i;
  end

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !span_full_i) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      span_q <= span_d;
    end
  end

  assign span_valid_o = valid_q;
  assign span_o       = span_q;

endmodule

FILE: src/hswm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hswm_queue: span queue
// Small FIFO of clipped spans between the front end and the word generator.
// ----------------------------------------------------------------------------
module hswm_queue import hswm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  span_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output span_t pop_data_o
);

  span_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/hswm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hswm_back: word write generator
// Walks the buffer words of one span, one word per cycle when not stalled,
// with partial masks at both ends, into an output register.
// ----------------------------------------------------------------------------
module hswm_back import hswm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 span_empty_i,
  input  span_t                span_i,
  output logic                 span_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [IDX_W-1:0]     word_index_o,
  output logic [WORD_BITS-1:0] bit_mask_o,
  output logic [COL_W-1:0]     write_colour_o,
  output logic                 last_write_o
);

  logic                 busy_q, busy_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [IDX_W-1:0]     sw_q, ew_q;
  logic [WB_LOG-1:0]    sb_q, eb_q;
  logic [COL_W-1:0]     col_q;
  logic                 out_valid_q, out_valid_d;
  logic [IDX_W-1:0]     out_idx_q;
  logic [WORD_BITS-1:0] out_mask_q, mask_d;
  logic [COL_W-1:0]     out_col_q;
  logic                 out_last_q;
  logic                 emit_ok, emit, load, at_end;

  assign emit_ok = !out_valid_q || !out_stall_i;
  assign emit    = busy_q && emit_ok;
  assign load    = !busy_q && !span_empty_i;
  assign at_end  = (cur_q == ew_q);
  assign span_pop_o = load;

  always_comb begin
    mask_d = '1;
    if (cur_q == sw_q) begin
      mask_d = mask_d & ({WORD_BITS{1'b1}} << sb_q);
    end
    if (at_end) begin
      mask_d = mask_d & ({WORD_BITS{1'b1}} >> (WB_LOG'(WORD_BITS - 1) - eb_q));
    end
  end

  always_comb begin
    busy_d      = busy_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    if (emit_ok) begin
      out_valid_d = emit;
    end
    if (emit) begin
      if (at_end) begin
        busy_d = 1'b0;
      end else begin
        cur_d = cur_q + IDX_W'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      cur_d  = span_i.start_bit[BIT_W-1:WB_LOG];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (load) begin
      sw_q  <= span_i.start_bit[BIT_W-1:WB_LOG];
      ew_q  <= span_i.end_bit[BIT_W-1:WB_LOG];
      sb_q  <= span_i.start_bit[WB_LOG-1:0];
      eb_q  <= span_i.end_bit[WB_LOG-1:0];
      col_q <= span_i.colour;
    end
    if (emit) begin
      out_idx_q  <= cur_q;
      out_mask_q <= mask_d;
      out_col_q  <= col_q;
      out_last_q <= at_end;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_index_o   = out_idx_q;
  assign bit_mask_o     = out_mask_q;
  assign write_colour_o = out_col_q;
  assign last_write_o   = out_last_q;

`ifndef SYNTHESIS
  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_q <= ew_q && cur_q >= sw_q))
    else $error("word counter outside span");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_pop_o |-> !busy_q)
    else $error("span popped while a span is in progress");

  a_tail_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_write_o) |-> busy_q)
    else $error("non-final word shown with no span in progress");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_pop_o |=> (busy_q && cur_q == sw_q))
    else $error("span load did not start at first word");
`endif

endmodule

FILE: src/horizontal_span_word_masks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// horizontal_span_word_masks: horizontal line to buffer word writes
// Clips raw line requests to the display and emits masked 32-bit word writes.
// ----------------------------------------------------------------------------
// A request is clipped and its bit range registered; requests that leave
// nothing on screen end there and produce no words. Visible spans wait in a
// two-entry queue for the word generator, which loads each span and then
// issues one word write per cycle while out_stall_i does not hold it. Word
// writes come out in ascending order with last_write_o on the final one.
// Display width and height are to be written through the cfg port only when
// idle; the block itself does not enforce this.
module horizontal_span_word_masks import hswm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [DIM_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] start_x_i,
  input  logic signed [COORD_W-1:0] start_y_i,
  input  logic [COORD_W-1:0]        line_length_i,
  input  logic [COL_W-1:0]          colour_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [IDX_W-1:0]          word_index_o,
  output logic [WORD_BITS-1:0]      bit_mask_o,
  output logic [COL_W-1:0]          write_colour_o,
  output logic                      last_write_o
);

  logic [DIM_W-1:0] display_width_q, display_width_d;
  logic [DIM_W-1:0] display_height_q, display_height_d;
  logic             front_valid, q_full, q_empty, q_pop;
  span_t            front_span, q_span;

  always_comb begin
    display_width_d  = display_width_q;
    display_height_d = display_height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DISPLAY_WIDTH:  display_width_d  = cfg_data_i;
        REG_DISPLAY_HEIGHT: display_height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_width_q  <= WIDTH_RESET;
      display_height_q <= HEIGHT_RESET;
    end else begin
      display_width_q  <= display_width_d;
      display_height_q <= display_height_d;
    end
  end

  hswm_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .display_width_i  (display_width_q),
    .display_height_i (display_height_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .line_length_i    (line_length_i),
    .colour_i         (colour_i),
    .span_valid_o     (front_valid),
    .span_full_i      (q_full),
    .span_o           (front_span)
  );

  hswm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_span),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_span)
  );

  hswm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .span_empty_i   (q_empty),
    .span_i         (q_span),
    .span_pop_o     (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .word_index_o   (word_index_o),
    .bit_mask_o     (bit_mask_o),
    .write_colour_o (write_colour_o),
    .last_write_o   (last_write_o)
  );

endmodule

FILE: test/tb_horizontal_span_word_masks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_horizontal_span_word_masks: self-checking bench for the span word writer
// Sends clipped and unclipped line requests under several display sizes and
// checks every word write against a predictor kept in a scoreboard class.
// Both handshakes get random gaps, and one long output hold-off backs up the
// block into its input.
// ----------------------------------------------------------------------------
module tb_horizontal_span_word_masks;
  import hswm_pkg::*;

  localparam int DRAIN_CYCLES  = 48;    // covers a line still in the clip stage
  localparam int HOLD_CYCLES   = 400;
  localparam int WATCHDOG_MAX  = 5000;

  typedef struct {
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] mask;
    logic [COL_W-1:0]     colour;
    logic                 last;
  } word_write_t;

  class line_scoreboard;
    logic [DIM_W-1:0] disp_width;
    logic [DIM_W-1:0] disp_height;
    word_write_t      pending_words[$];
    int               errors;

    function new();
      disp_width  = WIDTH_RESET;
      disp_height = HEIGHT_RESET;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_DISPLAY_WIDTH: begin
          disp_width = val;
        end
        REG_DISPLAY_HEIGHT: begin
          disp_height = val;
        end
        default: ;
      endcase
    endfunction

    // clip one line and queue the word writes it covers
    function void note_line(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic [COORD_W-1:0] len, logic [COL_W-1:0] col);
      int sx, sy, ln, w, h, end_x, from_x, span;
      int unsigned first_bit, last_bit, first_word, last_word;
      logic [WORD_BITS-1:0] full, head_mask, tail_mask;
      word_write_t wr;
      sx = int'(x);
      sy = int'(y);
      ln = int'(len);
      w  = int'(disp_width);
      h  = int'(disp_height);
      if (sy < 0 || sy >= h || sx >= w) return;
      end_x = sx + ln;
      if (end_x > w) end_x = w;
      if (end_x <= 0) return;
      from_x = (sx < 0) ? 0 : sx;
      span   = end_x - from_x;
      if (span <= 0) return;
      first_bit  = sy * (w + ROW_PAD) + from_x + 1;
      last_bit   = first_bit + span - 1;
      first_word = first_bit / WORD_BITS;
      last_word  = last_bit / WORD_BITS;
      full       = {WORD_BITS{1'b1}};
      head_mask  = full << (first_bit % WORD_BITS);
      tail_mask  = full >> (WORD_BITS - 1 - (last_bit % WORD_BITS));
      for (int unsigned wi = first_word; wi <= last_word; wi++) begin
        wr.index  = wi[IDX_W-1:0];
        wr.mask   = full;
        if (wi == first_word) wr.mask &= head_mask;
        if (wi == last_word) wr.mask &= tail_mask;
        wr.colour = col;
        wr.last   = (wi == last_word);
        pending_words.push_back(wr);
      end
    endfunction

    function void check_word(logic [IDX_W-1:0] idx, logic [WORD_BITS-1:0] mask,
                             logic [COL_W-1:0] col, logic last);
      word_write_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word: word_index %0d bit_mask %h", idx, mask);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (idx !== want.index) begin
        $error("word_index: expected %0d, actual %0d", want.index, idx);
        errors++;
      end
      if (mask !== want.mask) begin
        $error("bit_mask: expected %h, actual %h", want.mask, mask);
        errors++;
      end
      if (col !== want.colour) begin
        $error("write_colour: expected %h, actual %h", want.colour, col);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_write: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [DIM_W-1:0]          cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [COORD_W-1:0] start_x_i;
  logic signed [COORD_W-1:0] start_y_i;
  logic [COORD_W-1:0]        line_length_i;
  logic [COL_W-1:0]          colour_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [IDX_W-1:0]          word_index_o;
  logic [WORD_BITS-1:0]      bit_mask_o;
  logic [COL_W-1:0]          write_colour_o;
  logic                      last_write_o;

  line_scoreboard sb = new();
  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  horizontal_span_word_masks dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // output side: random stall runs, plus one long hold-off on request
  initial begin
    int run_len;
    bit stall_now;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_now = 1'b1;
        run_len   = HOLD_CYCLES;
      end else if (!idle_on) begin
        stall_now = 1'b0;
        run_len   = 1;
      end else begin
        stall_now = ($urandom_range(0, 99) < 35);
        run_len   = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
      end
      out_stall_i <= stall_now;
      repeat (run_len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(word_index_o, bit_mask_o, write_colour_o, last_write_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("horizontal_span_word_masks test failed");
        $finish;
      end
    end
  end

  function int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_line(input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] len,
                           input logic [COL_W-1:0] col);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    start_x_i     <= x;
    start_y_i     <= y;
    line_length_i <= len;
    colour_i      <= col;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_line(x, y, len, col);
  endtask

  // mostly on-screen lines with random content, some raw noise
  task automatic send_random_lines(input int count);
    logic signed [COORD_W-1:0] x, y;
    logic [COORD_W-1:0]        len;
    int w, h, r, tmp;
    for (int i = 0; i < count; i++) begin
      w = int'(sb.disp_width);
      h = int'(sb.disp_height);
      x = COORD_W'($urandom);
      y = COORD_W'($urandom);
      len = COORD_W'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        if (h > 0 && $urandom_range(0, 9) != 0) y = COORD_W'($urandom_range(0, h - 1));
        r = $urandom_range(0, 99);
        if (r < 70) begin
          x = (w > 0) ? COORD_W'($urandom_range(0, w - 1)) : '0;
        end else if (r < 90) begin
          tmp = -int'($urandom_range(1, 64));
          x = COORD_W'(tmp);
        end
        r = $urandom_range(0, 99);
        if (r < 5) len = '0;
        else if (r < 55) len = COORD_W'($urandom_range(0, 64));
        else if (r < 90) len = COORD_W'($urandom_range(0, w + 40));
      end
      send_line(x, y, len, COL_W'($urandom));
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic set_display(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    wait_idle();
    write_reg(REG_DISPLAY_WIDTH, w);
    write_reg(REG_DISPLAY_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_DISPLAY_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    start_x_i     = '0;
    start_y_i     = '0;
    line_length_i = '0;
    colour_i      = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry 360 x 288
    send_line(0, 0, 1, 8'h00);
    send_line(0, 0, 0, 8'hFF);             // zero length
    send_line(-1, 0, 1, 8'h12);            // clipped away on the left
    send_line(-10, 5, 20, 8'h55);          // partial left clip
    send_line(-2048, 10, 4095, 8'hAA);     // clipped on both ends
    send_line(2047, 0, 10, 8'h01);         // far right, off screen
    send_line(360, 0, 5, 8'h02);           // x at display width
    send_line(359, 287, 4095, 8'h80);      // last pixel of the screen
    send_line(0, -1, 5, 8'h03);
    send_line(0, -2048, 5, 8'h04);
    send_line(0, 288, 5, 8'h05);           // row at display height
    send_line(0, 2047, 5, 8'h06);
    send_line(30, 0, 2, 8'h07);            // straddles a word boundary
    send_line(31, 0, 1, 8'h08);            // word aligned start
    send_line(0, 3, 360, 8'h7F);           // full row
    send_line(100, 100, 4095, 8'hFE);      // right clip
    send_line(-2048, -2048, 0, 8'h00);
    send_random_lines(110);

    set_display(10'd1023, 10'd1023);
    send_line(-5, 1, 4095, 8'hC3);         // 33 word writes
    send_line(-5, 1022, 4095, 8'h3C);      // bottom row, highest word indexes
    send_line(1022, 1022, 1, 8'hE7);
    send_line(0, 0, 4095, 8'h18);
    hold_req = 1'b1;                       // back up the block into its input
    send_random_lines(120);

    set_display(10'd0, 10'd5);             // zero width: nothing on screen
    send_random_lines(25);
    set_display(10'd7, 10'd0);             // zero height
    send_random_lines(20);
    set_display(10'd1, 10'd1);
    send_random_lines(30);
    set_display(DIM_W'($urandom_range(8, 1023)), DIM_W'($urandom_range(1, 1023)));
    send_random_lines(100);

    set_display(10'd1023, 10'd64);
    idle_on = 1'b0;
    send_random_lines(80);

    wait_idle();
    if (sb.errors == 0)
      $display("horizontal_span_word_masks test passed");
    else
      $display("horizontal_span_word_masks test failed");
    $finish;
  end

endmodule
